// File: rtl/eps_pkg.sv
// types, codes and constants for the encoder period speed and position block
// no dependencies; imported by encoder_period_speed_position_top and the testbench files
package eps_pkg;

    // input item function codes
    localparam logic FUNC_CAPTURE = 1'b0;
    localparam logic FUNC_TICK    = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RPM_NUMERATOR     = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPEED_LIMIT       = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPEED_FLOOR       = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RADIANS_PER_COUNT = 2'd3;
    localparam int CFG_DATA_BITS = 31;

    // register widths and reset values
    localparam int NUM_BITS   = 24;
    localparam int LIMIT_BITS = 31;
    localparam int FLOOR_BITS = 16;
    localparam int RPC_BITS   = 24;
    localparam logic [NUM_BITS-1:0]   RPM_NUMERATOR_RST     = 24'd12600000;
    localparam logic [LIMIT_BITS-1:0] SPEED_LIMIT_RST       = 31'd1536000;
    localparam logic [FLOOR_BITS-1:0] SPEED_FLOOR_RST       = 16'd3;
    localparam logic [RPC_BITS-1:0]   RADIANS_PER_COUNT_RST = 24'd263536;

    // datapath widths
    localparam int SPEED_BITS = 32;
    localparam int POS_BITS   = 32;
    localparam int ANGLE_BITS = 48;
    localparam int PROD_BITS  = POS_BITS + RPC_BITS;
    localparam int FRAC_DROP  = 8;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_CHECK,
        ST_FLOOR,
        ST_MUL,
        ST_ROUND,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic               func;
        logic [15:0]        edge_period;
        logic               counting_down;
        logic signed [15:0] count_delta;
    } in_item_t;

    typedef struct packed {
        logic signed [SPEED_BITS-1:0] speed;
        logic signed [POS_BITS-1:0]   position;
        logic signed [ANGLE_BITS-1:0] angle;
    } out_item_t;

endpackage

// File: rtl/encoder_period_speed_position_top.sv
// encoder period speed and position: one channel, shared sequencer datapath
// Sequence: a capture runs ST_MUL, ST_ROUND, ST_OUT; a tick runs ST_FLOOR before them,
// and with a nonzero pending period ST_DIV (restoring divide, one quotient bit a cycle)
// and ST_CHECK first. The next item is taken the cycle after the result enters the output
// register, later while that register waits on m_ready.
// Reset (aresetn low, synchronous) clears state and position, loads register defaults.
module encoder_period_speed_position_top
    import eps_pkg::*;
#(
    parameter int PERIOD_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // configuration write port
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
    // input channel
    input  logic                     s_valid,
    output logic                     s_ready,
    input  in_item_t                 s_data,
    // result channel
    output logic                     m_valid,
    input  logic                     m_ready,
    output out_item_t                m_data
);

    localparam int QUO_BITS = SPEED_BITS;
    localparam int CNT_BITS = $clog2(QUO_BITS);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(QUO_BITS - 1);

    // configuration registers
    logic [NUM_BITS-1:0]   rpm_numerator_reg;
    logic [LIMIT_BITS-1:0] speed_limit_reg;
    logic [FLOOR_BITS-1:0] speed_floor_reg;
    logic [RPC_BITS-1:0]   rpc_reg;

    // channel state
    state_t                  state_reg, state_next;
    logic [PERIOD_BITS-1:0]  period_reg, period_next;
    logic                    down_reg, down_next;
    logic                    pending_reg, pending_next;
    logic [SPEED_BITS-1:0]   speed_reg, speed_next;
    logic [POS_BITS-1:0]     count_reg, count_next;

    // shared datapath registers
    logic [QUO_BITS-1:0]     dvd_reg, dvd_next;
    logic [PERIOD_BITS-1:0]  rem_reg, rem_next;
    logic [CNT_BITS-1:0]     cnt_reg, cnt_next;
    logic [PROD_BITS-1:0]    prod_reg, prod_next;
    logic                    neg_reg, neg_next;
    logic [ANGLE_BITS-1:0]   rnd_reg, rnd_next;
    logic                    m_valid_reg, m_valid_next;
    out_item_t               m_data_reg, m_data_next;

    // combinational helpers
    logic [PERIOD_BITS:0]    rem_shift;
    logic                    q_bit;
    logic [SPEED_BITS-1:0]   speed_mag;
    logic [POS_BITS-1:0]     pos_mag;
    logic                    out_free;
    logic                    in_xfer;

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_xfer  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign rem_shift  = {rem_reg, dvd_reg[QUO_BITS-1]};
    assign q_bit      = (rem_shift >= {1'b0, period_reg});
    assign speed_mag  = speed_reg[SPEED_BITS-1] ? (~speed_reg + 1'b1) : speed_reg;
    assign pos_mag    = count_reg[POS_BITS-1] ? (~count_reg + 1'b1) : count_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rpm_numerator_reg <= RPM_NUMERATOR_RST;
            speed_limit_reg   <= SPEED_LIMIT_RST;
            speed_floor_reg   <= SPEED_FLOOR_RST;
            rpc_reg           <= RADIANS_PER_COUNT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_RPM_NUMERATOR:     rpm_numerator_reg <= cfg_wdata[NUM_BITS-1:0];
                CFG_SPEED_LIMIT:       speed_limit_reg   <= cfg_wdata[LIMIT_BITS-1:0];
                CFG_SPEED_FLOOR:       speed_floor_reg   <= cfg_wdata[FLOOR_BITS-1:0];
                CFG_RADIANS_PER_COUNT: rpc_reg           <= cfg_wdata[RPC_BITS-1:0];
                default: ;
            endcase
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            period_reg  <= '0;
            down_reg    <= 1'b0;
            pending_reg <= 1'b0;
            speed_reg   <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            period_reg  <= period_next;
            down_reg    <= down_next;
            pending_reg <= pending_next;
            speed_reg   <= speed_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        prod_reg   <= prod_next;
        neg_reg    <= neg_next;
        rnd_reg    <= rnd_next;
        m_data_reg <= m_data_next;
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        period_next  = period_reg;
        down_next    = down_reg;
        pending_next = pending_reg;
        speed_next   = speed_reg;
        count_next   = count_reg;
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        prod_next    = prod_reg;
        neg_next     = neg_reg;
        rnd_next     = rnd_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;

        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (s_data.func == FUNC_CAPTURE) begin
                        // store the capture and move the position
                        period_next  = PERIOD_BITS'(s_data.edge_period);
                        down_next    = s_data.counting_down;
                        pending_next = 1'b1;
                        count_next   = count_reg
                                     + {{(POS_BITS-16){s_data.count_delta[15]}},
                                        s_data.count_delta};
                        state_next   = ST_MUL;
                    end else if (pending_reg) begin
                        pending_next = 1'b0;
                        if (period_reg == '0) begin
                            speed_next = '0;
                            state_next = ST_FLOOR;
                        end else begin
                            // start divide of numerator * 256 by the period
                            dvd_next   = {rpm_numerator_reg, {FRAC_DROP{1'b0}}};
                            rem_next   = '0;
                            cnt_next   = '0;
                            state_next = ST_DIV;
                        end
                    end else begin
                        state_next = ST_FLOOR;
                    end
                end
            end

            // one restoring divide step per cycle
            ST_DIV: begin
                rem_next = q_bit ? rem_shift[PERIOD_BITS-1:0] - period_reg
                                 : rem_shift[PERIOD_BITS-1:0];
                dvd_next = {dvd_reg[QUO_BITS-2:0], q_bit};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    state_next = ST_CHECK;
                end
            end

            // limit check and direction
            ST_CHECK: begin
                if (dvd_reg > {1'b0, speed_limit_reg}) begin
                    speed_next = '0;
                end else begin
                    speed_next = down_reg ? (~dvd_reg + 1'b1) : dvd_reg;
                end
                state_next = ST_FLOOR;
            end

            // small magnitudes go to zero
            ST_FLOOR: begin
                if (speed_mag < {{(SPEED_BITS-FLOOR_BITS){1'b0}}, speed_floor_reg}) begin
                    speed_next = '0;
                end
                state_next = ST_MUL;
            end

            // position magnitude times angle per count
            ST_MUL: begin
                prod_next  = PROD_BITS'(pos_mag) * PROD_BITS'(rpc_reg);
                neg_next   = count_reg[POS_BITS-1];
                state_next = ST_ROUND;
            end

            // drop eight fraction bits, rounding the magnitude up when negative
            ST_ROUND: begin
                rnd_next = prod_reg[FRAC_DROP +: ANGLE_BITS]
                         + {{(ANGLE_BITS-1){1'b0}},
                            (neg_reg && (prod_reg[FRAC_DROP-1:0] != '0))};
                state_next = ST_OUT;
            end

            // hand the result to the output register
            ST_OUT: begin
                if (out_free) begin
                    m_data_next.speed    = speed_reg;
                    m_data_next.position = count_reg;
                    m_data_next.angle    = neg_reg ? (~rnd_reg + 1'b1) : rnd_reg;
                    m_valid_next         = 1'b1;
                    state_next           = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: tb/sv/encoder_motion_checker.sv
// result checker for the encoder period speed and position block: predicts
// speed, position and angle per transfer and compares them. depends on eps_pkg
`timescale 1ns / 100ps

module encoder_motion_checker
    import eps_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  in_item_t                 s_data,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  out_item_t                m_data,
    output int                       mismatches,
    output int                       outstanding
);

    // shadow copy of the configuration registers
    logic [NUM_BITS-1:0]   numerator;
    logic [LIMIT_BITS-1:0] speed_limit;
    logic [FLOOR_BITS-1:0] speed_floor;
    logic [RPC_BITS-1:0]   rad_per_count;

    // shadow copy of the channel state
    logic [15:0]           held_period;
    logic                  held_down;
    logic                  capture_pending;
    logic [SPEED_BITS-1:0] speed_word;
    logic [POS_BITS-1:0]   position_sum;

    out_item_t expected_motion[$];
    out_item_t want;
    int        fail_count = 0;

    assign mismatches = fail_count;
    initial outstanding = 0;

    // one line per failure
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        $display("motion check: %s got %0h expected %0h", what, got, exp_val);
        fail_count++;
    endtask

    // advance the shadow state by one item and return the result it causes
    function automatic out_item_t predict_motion(input in_item_t it);
        out_item_t        r;
        logic [63:0]      quot;
        logic [31:0]      mag;
        logic signed [63:0] prod;
        if (it.func == FUNC_CAPTURE) begin
            held_period     = it.edge_period;
            held_down       = it.counting_down;
            capture_pending = 1'b1;
            position_sum    = position_sum + {{16{it.count_delta[15]}}, it.count_delta};
        end else begin
            // a pending capture turns into a new speed
            if (capture_pending) begin
                capture_pending = 1'b0;
                if (held_period == '0) begin
                    speed_word = '0;
                end else begin
                    quot = {32'd0, numerator, 8'd0} / {48'd0, held_period};
                    if (quot > {33'd0, speed_limit})
                        speed_word = '0;
                    else
                        speed_word = held_down ? -quot[31:0] : quot[31:0];
                end
            end
            // floor filter applies on every tick
            mag = speed_word[31] ? -speed_word : speed_word;
            if (mag < {16'd0, speed_floor})
                speed_word = '0;
        end
        r.speed    = speed_word;
        r.position = position_sum;
        // floor division by 256 of the signed product
        prod = $signed({{32{position_sum[31]}}, position_sum})
             * $signed({40'd0, rad_per_count});
        r.angle = prod[55:8];
        return r;
    endfunction

    // watch config writes, input transfers and result transfers
    always @(posedge aclk) begin
        if (!aresetn) begin
            numerator       = RPM_NUMERATOR_RST;
            speed_limit     = SPEED_LIMIT_RST;
            speed_floor     = SPEED_FLOOR_RST;
            rad_per_count   = RADIANS_PER_COUNT_RST;
            held_period     = '0;
            held_down       = 1'b0;
            capture_pending = 1'b0;
            speed_word      = '0;
            position_sum    = '0;
            expected_motion.delete();
        end else begin
            // results first, so a result never meets its own item's expectation early
            if (m_valid && m_ready) begin
                if (expected_motion.size() == 0) begin
                    report_mismatch("result with nothing expected, position",
                                    {32'd0, m_data.position}, '0);
                end else begin
                    want = expected_motion.pop_front();
                    if (m_data.speed !== want.speed)
                        report_mismatch("speed", {32'd0, m_data.speed}, {32'd0, want.speed});
                    if (m_data.position !== want.position)
                        report_mismatch("position", {32'd0, m_data.position},
                                        {32'd0, want.position});
                    if (m_data.angle !== want.angle)
                        report_mismatch("angle", {16'd0, m_data.angle}, {16'd0, want.angle});
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_RPM_NUMERATOR: begin
                        numerator = cfg_wdata[NUM_BITS-1:0];
                    end
                    CFG_SPEED_LIMIT: begin
                        speed_limit = cfg_wdata[LIMIT_BITS-1:0];
                    end
                    CFG_SPEED_FLOOR: begin
                        speed_floor = cfg_wdata[FLOOR_BITS-1:0];
                    end
                    CFG_RADIANS_PER_COUNT: begin
                        rad_per_count = cfg_wdata[RPC_BITS-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (s_valid && s_ready)
                expected_motion.push_back(predict_motion(s_data));
        end
        outstanding <= expected_motion.size();
    end

endmodule

// File: tb/sv/encoder_period_speed_position_top_tb.sv
// testbench top for encoder_period_speed_position_top: clock, reset, config
// writes, directed and random stimulus, verdict. depends on eps_pkg and encoder_motion_checker
`timescale 1ns / 100ps

module encoder_period_speed_position_top_tb;
    import eps_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 1560;
    localparam int SEGMENT_ITEMS  = 275;
    localparam int IDLE_SEGMENT   = 550;
    localparam int SWEEP_CAPTURES = 64;

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
    logic                     s_valid   = 1'b0;
    logic                     s_ready;
    in_item_t                 s_data    = '0;
    logic                     m_valid;
    logic                     m_ready   = 1'b0;
    out_item_t                m_data;

    int mismatches;
    int outstanding;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles  = 0;

    logic [NUM_BITS-1:0]   cur_num   = RPM_NUMERATOR_RST;
    logic [LIMIT_BITS-1:0] cur_limit = SPEED_LIMIT_RST;

    always #10 aclk = ~aclk;

    encoder_period_speed_position_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    encoder_motion_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // receiver stalls at random
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("encoder_period_speed_position_top: mismatch");
            $finish;
        end
    end

    function automatic in_item_t capture_item(input logic [15:0] period, input logic down,
                                              input logic [15:0] delta);
        in_item_t it;
        it.func          = FUNC_CAPTURE;
        it.edge_period   = period;
        it.counting_down = down;
        it.count_delta   = delta;
        return it;
    endfunction

    // ticks carry random junk in the ignored fields
    function automatic in_item_t tick_item();
        in_item_t it;
        it.func          = FUNC_TICK;
        it.edge_period   = 16'($urandom);
        it.counting_down = 1'($urandom);
        it.count_delta   = 16'($urandom);
        return it;
    endfunction

    // period mix: full range, tiny, huge, and around the speed limit boundary
    function automatic logic [15:0] pick_period();
        longint thr;
        case ($urandom_range(0, 3))
            0: begin
                return 16'($urandom);
            end
            1: begin
                return 16'($urandom_range(0, 4));
            end
            2: begin
                return 16'($urandom_range(16'hF000, 16'hFFFF));
            end
            default: begin
                thr = (longint'(cur_num) * 256) / (longint'(cur_limit) + 1);
                thr = thr + longint'($urandom_range(0, 2));
                if (thr > 65535)
                    thr = longint'($urandom_range(0, 65535));
                return thr[15:0];
            end
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic load_settings(input logic [NUM_BITS-1:0] num,
                                 input logic [LIMIT_BITS-1:0] lim,
                                 input logic [FLOOR_BITS-1:0] flr,
                                 input logic [RPC_BITS-1:0] rpc);
        write_reg(CFG_RPM_NUMERATOR, CFG_DATA_BITS'(num));
        write_reg(CFG_SPEED_LIMIT, CFG_DATA_BITS'(lim));
        write_reg(CFG_SPEED_FLOOR, CFG_DATA_BITS'(flr));
        write_reg(CFG_RADIANS_PER_COUNT, CFG_DATA_BITS'(rpc));
        cfg_we    <= 1'b0;
        cur_num   = num;
        cur_limit = lim;
    endtask

    // hold the sender until every expected result is in
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic send_item(input in_item_t it);
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do
            @(posedge aclk);
        while (!s_ready);
    endtask

    // register settings per random segment: maxima with a zero floor, minima with the largest floor, then random
    task automatic apply_settings(input int seg);
        logic [FLOOR_BITS-1:0] flr;
        case (seg)
            0: begin
                load_settings(24'hFFFFFF, 31'h7FFFFFFF, 16'd0, 24'hFFFFFF);
            end
            1: begin
                load_settings(24'd1, 31'd0, 16'hFFFF, 24'd0);
            end
            default: begin
                flr = ($urandom_range(0, 3) == 0) ? FLOOR_BITS'($urandom_range(0, 65535))
                                                  : FLOOR_BITS'($urandom_range(0, 255));
                load_settings(NUM_BITS'($urandom_range(1, 24'hFFFFFF)),
                              LIMIT_BITS'($urandom >> $urandom_range(1, 31)), flr,
                              RPC_BITS'($urandom));
            end
        endcase
    endtask

    initial begin
        int n;
        int seg;
        int cur_seg;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part with reset defaults
        send_item('{FUNC_TICK, 16'hFFFF, 1'b1, 16'hFFFF});      // tick with nothing captured
        send_item(capture_item(16'd0, 1'b0, 16'd0));
        send_item(tick_item());                                 // zero period
        send_item(capture_item(16'hFFFF, 1'b1, 16'h8000));
        send_item(tick_item());                                 // slowest, counting down
        send_item(tick_item());                                 // speed held
        send_item(capture_item(16'd1, 1'b0, 16'h7FFF));
        send_item(tick_item());                                 // far over the limit
        send_item(capture_item(16'd2100, 1'b0, 16'd1));
        send_item(tick_item());                                 // exactly at the limit
        send_item(capture_item(16'd2099, 1'b0, 16'd1));
        send_item(tick_item());                                 // just over the limit
        send_item(capture_item(16'd40, 1'b0, 16'h1234));
        send_item(capture_item(16'd3000, 1'b1, 16'hFFFF));      // later capture wins
        send_item(tick_item());
        send_item(capture_item(16'h8000, 1'b1, 16'h5555));
        drain();

        // floor filter with a tiny numerator
        write_reg(CFG_RPM_NUMERATOR, 31'd1);
        cfg_we  <= 1'b0;
        cur_num = 24'd1;
        send_item(capture_item(16'd100, 1'b0, 16'd0));
        send_item(tick_item());                                 // below floor
        send_item(capture_item(16'd85, 1'b1, 16'hAAAA));
        send_item(tick_item());                                 // just at floor
        drain();
        write_reg(CFG_SPEED_FLOOR, 31'hFFFF);
        cfg_we <= 1'b0;
        send_item(tick_item());                                 // raised floor zeroes held speed
        drain();

        // random part: capture/tick pairs mostly, loose items otherwise
        n       = 0;
        cur_seg = -1;
        while (n < RANDOM_ITEMS) begin
            seg = n / SEGMENT_ITEMS;
            if (seg != cur_seg) begin
                drain();
                apply_settings(seg);
                cur_seg = seg;
                case (n / IDLE_SEGMENT)
                    0: begin
                        send_idle_pct = 24;
                        recv_idle_pct = 70;
                    end
                    1: begin
                        send_idle_pct = 70;
                        recv_idle_pct = 24;
                    end
                    default: begin
                        send_idle_pct = 0;
                        recv_idle_pct = 0;
                    end
                endcase
            end
            if ($urandom_range(0, 4) != 0) begin
                send_item(capture_item(pick_period(), 1'($urandom), 16'($urandom)));
                send_item(tick_item());
                n += 2;
            end else begin
                if ($urandom_range(0, 1) == 0)
                    send_item(capture_item(pick_period(), 1'($urandom), 16'($urandom)));
                else
                    send_item(tick_item());
                n += 1;
            end
        end
        drain();

        // back to back captures with the largest positive delta
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_settings(NUM_BITS'($urandom_range(1, 24'hFFFFFF)), 31'h7FFFFFFF, 16'd0,
                      24'hFFFFFF);
        for (int i = 0; i < SWEEP_CAPTURES; i++)
            send_item(capture_item(pick_period(), 1'($urandom), 16'h7FFF));
        send_item(tick_item());
        drain();

        repeat (40) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("encoder_period_speed_position_top: match");
        else
            $display("encoder_period_speed_position_top: mismatch");
        $finish;
    end

endmodule
